@@ rtl/e3d_pkg.sv @@
// Shared types, constants and the CRC-8 helper for the ESP3 telegram deframer.
`default_nettype none

package e3d_pkg;

    localparam int HDR_BYTES = 6;
    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int TDATA_W = 80;

    // Result event codes
    localparam logic [2:0] EV_HDR_OK     = 3'd0;
    localparam logic [2:0] EV_DATA       = 3'd1;
    localparam logic [2:0] EV_OPTION     = 3'd2;
    localparam logic [2:0] EV_FRAME_OK   = 3'd3;
    localparam logic [2:0] EV_CRC_ERR    = 3'd4;
    localparam logic [2:0] EV_HDR_REJECT = 3'd5;

    // Configuration register indexes
    localparam logic REG_SYNC_VALUE   = 1'b0;
    localparam logic REG_MAX_DATA_LEN = 1'b1;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [15:0] max_data_len;
    } cfg_t;

    // One classified event as it sits in the queue between front and back.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  packet_type;
        logic [15:0] data_length;
        logic [7:0]  option_length;
    } item_t;

    // CRC-8, MSB first, no reflection, no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/e3d_front.sv @@
// Front end: header hunting window, section tracking and running CRC per received byte.
`default_nettype none

module e3d_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire e3d_pkg::cfg_t      cfg,
    input  wire logic               in_valid,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_ready,
    output logic                    push,
    output e3d_pkg::item_t          item
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_OPTION = 2'd2;
    localparam logic [1:0] PH_CRC    = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  win_reg  [e3d_pkg::HDR_BYTES];
    logic [7:0]  win_next [e3d_pkg::HDR_BYTES];
    logic [7:0]  cand     [e3d_pkg::HDR_BYTES];
    logic [2:0]  fill_reg, fill_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [7:0]  olen_reg, olen_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  crc_reg, crc_next;

    logic        accept;
    logic        full;
    logic [15:0] cand_dlen;
    logic [7:0]  hdr_crc;
    logic        hdr_good;
    logic [16:0] cnt_inc;
    logic [7:0]  crc_upd;

    assign accept  = in_valid && in_ready;
    assign full    = (fill_reg == 3'(e3d_pkg::HDR_BYTES - 1));
    assign cnt_inc = {1'b0, cnt_reg} + 17'd1;
    assign crc_upd = e3d_pkg::crc8_byte(crc_reg, in_byte);

    always_comb
    begin
        for (int i = 0; i < e3d_pkg::HDR_BYTES; i++)
        begin
            cand[i] = (fill_reg == 3'(i)) ? in_byte : win_reg[i];
        end
    end

    assign cand_dlen = {cand[1], cand[2]};
    assign hdr_crc = e3d_pkg::crc8_byte(e3d_pkg::crc8_byte(e3d_pkg::crc8_byte(
                     e3d_pkg::crc8_byte(8'h00, cand[1]), cand[2]), cand[3]), cand[4]);
    assign hdr_good = (cand[0] == cfg.sync_value) && (cand_dlen <= cfg.max_data_len)
                      && (hdr_crc == cand[5]);

    always_comb
    begin
        phase_next = phase_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        dlen_next  = dlen_reg;
        olen_next  = olen_reg;
        type_next  = type_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        push       = 1'b0;
        item       = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (!full)
                    begin
                        win_next  = cand;
                        fill_next = fill_reg + 3'd1;
                    end
                    else if (!hdr_good)
                    begin
                        // Slide by one byte and keep checking on every later byte.
                        for (int i = 0; i < e3d_pkg::HDR_BYTES - 1; i++)
                        begin
                            win_next[i] = cand[i + 1];
                        end
                        win_next[e3d_pkg::HDR_BYTES - 1] = 8'h00;
                        push           = 1'b1;
                        item.event_res = e3d_pkg::EV_HDR_REJECT;
                    end
                    else
                    begin
                        dlen_next = cand_dlen;
                        olen_next = cand[3];
                        type_next = cand[4];
                        cnt_next  = '0;
                        crc_next  = '0;
                        fill_next = '0;
                        for (int i = 0; i < e3d_pkg::HDR_BYTES; i++)
                        begin
                            win_next[i] = 8'h00;
                        end
                        if (cand_dlen != 16'd0)
                            phase_next = PH_DATA;
                        else if (cand[3] != 8'd0)
                            phase_next = PH_OPTION;
                        else
                            phase_next = PH_CRC;
                        push               = 1'b1;
                        item.event_res     = e3d_pkg::EV_HDR_OK;
                        item.packet_type   = cand[4];
                        item.data_length   = cand_dlen;
                        item.option_length = cand[3];
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc_upd;
                    if (cnt_inc >= {1'b0, dlen_reg})
                    begin
                        cnt_next   = '0;
                        phase_next = (olen_reg != 8'd0) ? PH_OPTION : PH_CRC;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[15:0];
                    end
                    push               = 1'b1;
                    item.event_res     = e3d_pkg::EV_DATA;
                    item.payload_byte  = in_byte;
                    item.byte_index    = cnt_reg;
                    item.packet_type   = type_reg;
                    item.data_length   = dlen_reg;
                    item.option_length = olen_reg;
                end
                PH_OPTION:
                begin
                    crc_next = crc_upd;
                    if (cnt_inc >= {9'd0, olen_reg})
                    begin
                        cnt_next   = '0;
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[15:0];
                    end
                    push               = 1'b1;
                    item.event_res     = e3d_pkg::EV_OPTION;
                    item.payload_byte  = in_byte;
                    item.byte_index    = cnt_reg;
                    item.packet_type   = type_reg;
                    item.data_length   = dlen_reg;
                    item.option_length = olen_reg;
                end
                PH_CRC:
                begin
                    push               = 1'b1;
                    item.event_res     = (in_byte == crc_reg) ? e3d_pkg::EV_FRAME_OK
                                                              : e3d_pkg::EV_CRC_ERR;
                    item.packet_type   = type_reg;
                    item.data_length   = dlen_reg;
                    item.option_length = olen_reg;
                    // Hunt again from an empty window; payload is not rescanned.
                    phase_next = PH_HUNT;
                    cnt_next   = '0;
                    crc_next   = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            fill_reg  <= '0;
            dlen_reg  <= '0;
            olen_reg  <= '0;
            type_reg  <= '0;
            cnt_reg   <= '0;
            crc_reg   <= '0;
            for (int i = 0; i < e3d_pkg::HDR_BYTES; i++)
            begin
                win_reg[i] <= 8'h00;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            dlen_reg  <= dlen_next;
            olen_reg  <= olen_next;
            type_reg  <= type_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            win_reg   <= win_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'(e3d_pkg::HDR_BYTES - 1))
        else $error("header window fill out of range");

    a_fill_empty_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HUNT) |-> (fill_reg == 3'd0))
        else $error("window not empty while inside a frame");

    a_push_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_CRC)) |=> (phase_reg == PH_HUNT))
        else $error("frame end did not return to hunting");

endmodule

`default_nettype wire

@@ rtl/e3d_queue.sv @@
// Short event queue that decouples the byte classifier from the output stage.
`default_nettype none

module e3d_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire e3d_pkg::item_t     push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output e3d_pkg::item_t          head_item
);

    e3d_pkg::item_t mem [e3d_pkg::Q_DEPTH];

    logic [e3d_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [e3d_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [e3d_pkg::Q_CNT_W-1:0] count_reg;

    assign full      = (count_reg == e3d_pkg::Q_CNT_W'(e3d_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("event queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("event queue read while empty");

endmodule

`default_nettype wire

@@ rtl/e3d_back.sv @@
// Back end: formats queued events into the output register and drives the result stream.
`default_nettype none

module e3d_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_not_empty,
    input  wire e3d_pkg::item_t               q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [e3d_pkg::TDATA_W-1:0]       out_data,
    output logic [2:0]                        out_kind
);

    logic                         valid_reg;
    logic [e3d_pkg::TDATA_W-1:0]  data_reg, data_next;
    logic [2:0]                   kind_reg;
    logic                         hdr_fields;
    logic                         has_flen;
    logic [16:0]                  flen;

    assign q_pop = q_not_empty && (!valid_reg || out_ready);

    assign hdr_fields = (q_item.event_res != e3d_pkg::EV_HDR_REJECT);
    assign has_flen   = (q_item.event_res == e3d_pkg::EV_FRAME_OK) ||
                        (q_item.event_res == e3d_pkg::EV_CRC_ERR);
    assign flen       = 17'd7 + {1'b0, q_item.data_length} + {9'd0, q_item.option_length};

    always_comb
    begin
        data_next = {7'd0,
                     has_flen   ? flen                 : 17'd0,
                     hdr_fields ? q_item.option_length : 8'd0,
                     hdr_fields ? q_item.data_length   : 16'd0,
                     hdr_fields ? q_item.packet_type   : 8'd0,
                     q_item.byte_index,
                     q_item.payload_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= data_next;
            kind_reg <= q_item.event_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;

endmodule

`default_nettype wire

@@ rtl/esp3_telegram_deframer.sv @@
// Top level of the ESP3 telegram deframer: configuration registers and stream wiring.
//
// Received bytes arrive one per transaction on the s_axis channel (s_tdata[7:0]).
// Every byte that completes a header check, belongs to a frame body or is the
// frame CRC produces one event transaction on the m_axis channel; bytes that
// only fill the header window produce none. The event code travels in m_tuser.
// sync_value (address 0) and max_data_len (address 4) are set through the APB
// port; the user must do so only while idle, which the block does not enforce.
// The classifier writes each accepted byte's event into the queue at the accepting
// edge, and the output register takes it from the queue once that register is
// empty or being read. The header CRC and the running CRC are combinational, so
// one byte is accepted every cycle while the event queue is not full.
// When the receiver stalls, the four-entry event queue plus the output register
// absorb events; s_tready drops only once the queue is full.
// Reset returns the registers to 0x55 and 1024, empties the queue and the
// header window and starts hunting.
`default_nettype none

module esp3_telegram_deframer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // rx_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // payload_byte, byte_index, packet_type, data_length, option_length, frame_length
    output logic [e3d_pkg::TDATA_W-1:0]       m_tdata,
    output logic [2:0]                        m_tuser,   // event_res
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [7:0]      sync_reg;
    logic [15:0]     maxlen_reg;
    e3d_pkg::cfg_t   cfg;
    logic            cfg_write;

    logic            push;
    e3d_pkg::item_t  push_item;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    e3d_pkg::item_t  head_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= 8'h55;
            maxlen_reg <= 16'd1024;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                e3d_pkg::REG_SYNC_VALUE:   sync_reg   <= pwdata[7:0];
                e3d_pkg::REG_MAX_DATA_LEN: maxlen_reg <= pwdata[15:0];
                default:                   sync_reg   <= sync_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            e3d_pkg::REG_SYNC_VALUE:   prdata = {24'd0, sync_reg};
            e3d_pkg::REG_MAX_DATA_LEN: prdata = {16'd0, maxlen_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.sync_value   = sync_reg;
    assign cfg.max_data_len = maxlen_reg;
    assign s_tready         = !q_full;

    e3d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .push     (push),
        .item     (push_item)
    );

    e3d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    e3d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_kind    (m_tuser)
    );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the ESP3 telegram deframer: byte stream in, event stream out.
`default_nettype none

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 200;

    typedef enum logic [1:0] {HUNTING, IN_DATA, IN_OPTION, AT_CRC} deframe_phase_t;
    typedef enum int {FLAW_NONE, FLAW_SYNC, FLAW_HDR_CRC, FLAW_LENGTH, FLAW_BODY_CRC} flaw_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  packet_type;
        logic [15:0] data_length;
        logic [7:0]  option_length;
        logic [16:0] frame_length;
    } deframe_event_t;

    class deframer_scoreboard;
        logic [7:0]     sync_value;
        logic [15:0]    max_data_len;
        deframe_phase_t phase;
        logic [7:0]     window [e3d_pkg::HDR_BYTES];
        int             fill;
        logic [15:0]    held_dlen;
        logic [7:0]     held_olen;
        logic [7:0]     held_type;
        logic [15:0]    section_idx;
        logic [7:0]     body_crc;
        deframe_event_t expected_q [$];
        int             errors;
        int             seen [8];

        function new();
            sync_value = 8'h55;
            max_data_len = 16'd1024;
            held_dlen = '0;
            held_olen = '0;
            held_type = '0;
            errors = 0;
            foreach (seen[i])
                seen[i] = 0;
            restart_hunt();
        endfunction

        function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int k = 0; k < 8; k++)
                c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
            return c;
        endfunction

        function void restart_hunt();
            phase = HUNTING;
            fill = 0;
            foreach (window[i])
                window[i] = 8'h00;
            section_idx = '0;
            body_crc = '0;
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == e3d_pkg::REG_SYNC_VALUE)
                sync_value = value[7:0];
            else
                max_data_len = value[15:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_event(input logic [2:0] ev, input logic [7:0] pb,
                                 input logic [15:0] idx, input logic with_hdr,
                                 input logic with_len);
            deframe_event_t e;
            e.event_res = ev;
            e.payload_byte = pb;
            e.byte_index = idx;
            e.packet_type = with_hdr ? held_type : 8'h00;
            e.data_length = with_hdr ? held_dlen : 16'h0000;
            e.option_length = with_hdr ? held_olen : 8'h00;
            e.frame_length = with_len ? (17'd7 + {1'b0, held_dlen} + {9'd0, held_olen})
                                      : 17'd0;
            expected_q.push_back(e);
        endfunction

        // Called for every accepted byte; queues the event it must cause, if any.
        function void note_byte(input logic [7:0] b);
            logic [15:0] dlen;
            logic [7:0]  hc;
            case (phase)
                HUNTING:
                begin
                    if (fill < e3d_pkg::HDR_BYTES)
                    begin
                        window[fill] = b;
                        fill++;
                    end
                    if (fill < e3d_pkg::HDR_BYTES)
                        return;
                    dlen = {window[1], window[2]};
                    hc = 8'h00;
                    for (int i = 1; i < 5; i++)
                        hc = crc_step(hc, window[i]);
                    if (window[0] != sync_value || dlen > max_data_len || hc != window[5])
                    begin
                        // A failed header slides by one byte, so the next byte checks again.
                        for (int i = 0; i < e3d_pkg::HDR_BYTES - 1; i++)
                            window[i] = window[i + 1];
                        window[e3d_pkg::HDR_BYTES - 1] = 8'h00;
                        fill = e3d_pkg::HDR_BYTES - 1;
                        push_event(e3d_pkg::EV_HDR_REJECT, 8'h00, 16'h0000, 1'b0, 1'b0);
                    end
                    else
                    begin
                        held_dlen = dlen;
                        held_olen = window[3];
                        held_type = window[4];
                        section_idx = '0;
                        body_crc = '0;
                        if (held_dlen != 0)
                            phase = IN_DATA;
                        else if (held_olen != 0)
                            phase = IN_OPTION;
                        else
                            phase = AT_CRC;
                        push_event(e3d_pkg::EV_HDR_OK, 8'h00, 16'h0000, 1'b1, 1'b0);
                    end
                end
                IN_DATA:
                begin
                    body_crc = crc_step(body_crc, b);
                    push_event(e3d_pkg::EV_DATA, b, section_idx, 1'b1, 1'b0);
                    if (section_idx == held_dlen - 16'd1)
                    begin
                        section_idx = '0;
                        phase = (held_olen != 0) ? IN_OPTION : AT_CRC;
                    end
                    else
                        section_idx++;
                end
                IN_OPTION:
                begin
                    body_crc = crc_step(body_crc, b);
                    push_event(e3d_pkg::EV_OPTION, b, section_idx, 1'b1, 1'b0);
                    if (section_idx == {8'h00, held_olen} - 16'd1)
                    begin
                        section_idx = '0;
                        phase = AT_CRC;
                    end
                    else
                        section_idx++;
                end
                default:
                begin
                    push_event((b == body_crc) ? e3d_pkg::EV_FRAME_OK : e3d_pkg::EV_CRC_ERR,
                               8'h00, 16'h0000, 1'b1, 1'b1);
                    restart_hunt();
                end
            endcase
        endfunction

        function void compare(input string field, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_event(input logic [2:0] ev,
                                  input logic [e3d_pkg::TDATA_W-1:0] data);
            deframe_event_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: event %0d arrived with nothing expected, tdata %h",
                         $time, ev, data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            seen[want.event_res]++;
            compare("event_res", want.event_res, ev);
            compare("payload_byte", want.payload_byte, data[7:0]);
            compare("byte_index", want.byte_index, data[23:8]);
            compare("packet_type", want.packet_type, data[31:24]);
            compare("data_length", want.data_length, data[47:32]);
            compare("option_length", want.option_length, data[55:48]);
            compare("frame_length", want.frame_length, data[72:56]);
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [7:0]                   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [e3d_pkg::TDATA_W-1:0]  m_tdata;
    logic [2:0]                   m_tuser;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [2:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    deframer_scoreboard  sb;
    int                  items_sent;
    int                  burst_left;
    logic [7:0]          cur_sync;
    logic [15:0]         cur_max;

    esp3_telegram_deframer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sender side: bursts of random length separated by short gaps.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
            burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(150, 40)
                                                     : $urandom_range(16, 1);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_telegram(input logic [15:0] dlen, input logic [7:0] olen,
                                 input logic [7:0] ptype, input flaw_t flaw);
        logic [7:0] hdr [e3d_pkg::HDR_BYTES];
        logic [7:0] crc;
        logic [7:0] b;
        hdr[0] = cur_sync;
        hdr[1] = dlen[15:8];
        hdr[2] = dlen[7:0];
        hdr[3] = olen;
        hdr[4] = ptype;
        hdr[5] = 8'h00;
        for (int i = 1; i < 5; i++)
            hdr[5] = sb.crc_step(hdr[5], hdr[i]);
        if (flaw == FLAW_SYNC)
            hdr[0] ^= 8'($urandom_range(255, 1));
        if (flaw == FLAW_HDR_CRC)
            hdr[5] ^= 8'($urandom_range(255, 1));
        foreach (hdr[i])
            send_byte(hdr[i]);
        // A broken header is followed directly by whatever comes next.
        if (flaw == FLAW_SYNC || flaw == FLAW_HDR_CRC || flaw == FLAW_LENGTH)
            return;
        crc = 8'h00;
        for (int i = 0; i < int'(dlen) + int'(olen); i++)
        begin
            b = 8'($urandom);
            crc = sb.crc_step(crc, b);
            send_byte(b);
        end
        if (flaw == FLAW_BODY_CRC)
            crc ^= 8'($urandom_range(255, 1));
        send_byte(crc);
    endtask

    task automatic random_traffic(input int quota);
        int first;
        int kind;
        int cap;
        logic [15:0] dlen;
        logic [7:0]  olen;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            kind = $urandom_range(19, 0);
            cap = ($urandom_range(15, 0) == 0) ? 48 : 8;
            if (cap > cur_max)
                cap = cur_max;
            dlen = 16'($urandom_range(cap, 0));
            olen = ($urandom_range(39, 0) == 0) ? 8'd255 : 8'($urandom_range(6, 0));
            if (kind < 2)
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
            else if (kind == 2)
                send_telegram(dlen, olen, 8'($urandom), FLAW_SYNC);
            else if (kind == 3)
                send_telegram(dlen, olen, 8'($urandom), FLAW_HDR_CRC);
            else if (kind == 4 && cur_max != 16'hFFFF)
                send_telegram(16'($urandom_range(65535, cur_max + 1)), olen, 8'($urandom),
                              FLAW_LENGTH);
            else if (kind < 7)
                send_telegram(dlen, olen, 8'($urandom), FLAW_BODY_CRC);
            else
                send_telegram(dlen, olen, 8'($urandom), FLAW_NONE);
        end
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every expected event is out, plus the pipeline depth.
    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        items_sent = 0;
        burst_left = 0;
        cur_sync = 8'h55;
        cur_max = 16'd1024;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'h0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset settings.
        send_telegram(16'd0, 8'd0, 8'h00, FLAW_BODY_CRC);
        send_telegram(16'd1025, 8'd0, 8'h3C, FLAW_LENGTH);
        send_telegram(16'd1, 8'd0, 8'hFF, FLAW_NONE);
        send_telegram(16'd0, 8'd1, 8'h80, FLAW_NONE);

        for (int p = 0; p < 5; p++)
        begin
            s_tvalid <= 1'b0;
            drain_results();
            case (p)
                0:
                begin
                    cur_sync = 8'hA5;
                    cur_max = 16'd16;
                end
                1:
                begin
                    cur_sync = 8'h00;
                    cur_max = 16'd0;
                end
                2:
                begin
                    cur_sync = 8'hFF;
                    cur_max = 16'hFFFF;
                end
                3:
                begin
                    cur_sync = 8'h55;
                    cur_max = 16'd1024;
                end
                default:
                begin
                    cur_sync = 8'($urandom);
                    cur_max = 16'($urandom_range(300, 0));
                end
            endcase
            write_register(e3d_pkg::REG_SYNC_VALUE, {24'h0, cur_sync});
            write_register(e3d_pkg::REG_MAX_DATA_LEN, {16'h0, cur_max});
            random_traffic(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        drain_results();
        $display("Sent %0d bytes: %0d headers, %0d data, %0d option, %0d good frames,",
                 items_sent, sb.seen[e3d_pkg::EV_HDR_OK], sb.seen[e3d_pkg::EV_DATA],
                 sb.seen[e3d_pkg::EV_OPTION], sb.seen[e3d_pkg::EV_FRAME_OK]);
        $display("%0d bad data CRCs and %0d rejected headers over six register settings.",
                 sb.seen[e3d_pkg::EV_CRC_ERR], sb.seen[e3d_pkg::EV_HDR_REJECT]);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver side: a long hold right after reset so the event queue fills and
    // backpressure reaches the input, then segments of varying stall patterns.
    initial
    begin
        int mode;
        int len;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (60) @(negedge clk);
        forever
        begin
            mode = $urandom_range(7, 0);
            len = $urandom_range(80, 10);
            for (int k = 0; k < len; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready <= 1'b0;
                    1, 2:    m_tready <= 1'b1;
                    3, 4:    m_tready <= (k % 3 != 0);
                    default: m_tready <= ($urandom_range(1, 0) == 1);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_event(m_tuser, m_tdata);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles, %0d events still expected",
                 $time, STALL_LIMIT, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
